// ===== rtl/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing test.
package pip_pkg;

    // Width of the crossings field in a result.
    localparam int CROSS_BITS = 13;

    // Width of a configuration register index.
    localparam int CFG_ADDR_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_POINT_X = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_POINT_Y = 1'b1;

    // Packed result width, rounded up to whole bytes.
    localparam int RES_BITS   = 1 + CROSS_BITS;
    localparam int RES_TBITS  = ((RES_BITS + 7) / 8) * 8;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic [CROSS_BITS-1:0] crossings;
        logic                  inside_res;
    } res_t;

endpackage

// ===== rtl/pip_mul.sv =====
// Shared signed multiplier with a registered product.
module pip_mul
    import pip_pkg::*;
#(
    parameter int OP_BITS = 17
) (
    input  logic                        aclk,
    input  logic                        mul_en,
    input  logic signed [OP_BITS-1:0]   op_a,
    input  logic signed [OP_BITS-1:0]   op_b,
    output logic signed [2*OP_BITS-1:0] product
);

    logic signed [2*OP_BITS-1:0] prod_reg;

    // The product holds while the unit is not enabled.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign product = prod_reg;

endmodule

// ===== rtl/pip_ctrl.sv =====
// Sequencer: edge offsets, two multiplier passes, crossing decision and count.
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int MAX_EDGES  = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Edge transfer
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic                  last_edge,
    // Query point
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    // Result hand-off
    input  logic                  res_free,
    output logic                  res_push,
    output res_t                  res
);

    localparam int OP_BITS = COORD_BITS + 1;
    localparam int PW      = 2 * OP_BITS;
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DECIDE
    } state_t;

    state_t                    state_reg;
    logic signed [OP_BITS-1:0] da_reg;
    logic signed [OP_BITS-1:0] db_reg;
    logic signed [OP_BITS-1:0] dex_reg;
    logic signed [OP_BITS-1:0] dsx_reg;
    logic                      last_reg;
    logic signed [PW-1:0]      p1_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;

    logic signed [OP_BITS-1:0] op_a;
    logic signed [OP_BITS-1:0] op_b;
    logic signed [PW-1:0]      mul_p;
    logic                      mul_en;
    logic                      hit;
    logic                      advance;

    // Offsets of the edge ends from the query point, one bit wider than a coordinate.
    logic signed [OP_BITS-1:0] da_in;
    logic signed [OP_BITS-1:0] db_in;
    logic signed [OP_BITS-1:0] dex_in;
    logic signed [OP_BITS-1:0] dsx_in;

    always_comb begin
        da_in  = $signed({start_y[COORD_BITS-1], start_y})
               - $signed({point_y[COORD_BITS-1], point_y});
        db_in  = $signed({end_y[COORD_BITS-1], end_y})
               - $signed({point_y[COORD_BITS-1], point_y});
        dex_in = $signed({end_x[COORD_BITS-1], end_x})
               - $signed({point_x[COORD_BITS-1], point_x});
        dsx_in = $signed({start_x[COORD_BITS-1], start_x})
               - $signed({point_x[COORD_BITS-1], point_x});
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_en = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B);
        if (state_reg == ST_MUL_A) begin
            op_a = da_reg;
            op_b = dex_reg;
        end else begin
            op_a = db_reg;
            op_b = dsx_reg;
        end
    end

    pip_mul #(
        .OP_BITS (OP_BITS)
    ) u_mul (
        .aclk    (aclk),
        .mul_en  (mul_en),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (mul_p)
    );

    // Crossing test: the edge straddles the line and the cross product has the right sign.
    always_comb begin
        hit = (!da_reg[OP_BITS-1] && db_reg[OP_BITS-1] && (p1_reg > mul_p))
           || (da_reg[OP_BITS-1] && !db_reg[OP_BITS-1] && (p1_reg < mul_p));
        if (hit && (cnt_reg < CNT_W'(MAX_EDGES))) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // The decision step finishes unless a result is due and the output slot is full.
    assign advance  = (state_reg == ST_DECIDE) && (!last_reg || res_free);
    assign in_ready = (state_reg == ST_IDLE);
    assign res_push = advance && last_reg;

    always_comb begin
        res.inside_res = cnt_next[0];
        res.crossings  = CROSS_BITS'(cnt_next);
    end

    // State, operands and the crossing count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        da_reg    <= da_in;
                        db_reg    <= db_in;
                        dex_reg   <= dex_in;
                        dsx_reg   <= dsx_in;
                        last_reg  <= last_edge;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    p1_reg    <= mul_p;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (advance) begin
                        cnt_reg   <= last_reg ? '0 : cnt_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/point_in_polygon_crossing_test.sv =====
// Top level: configuration registers, edge sequencer and result register.
// Each edge goes through the transfer, two passes of the shared multiplier
// and the decision step; s_tready rises again in the cycle after the decision.
// A result shows on m_tvalid from the result register, loaded at the decision of the last edge.
// The decision of a last edge waits while the result register still holds an untaken result.
// Synchronous active-low reset clears the point registers, the count and m_tvalid.
module point_in_polygon_crossing_test
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int MAX_EDGES  = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [COORD_BITS-1:0]            cfg_wdata,
    // Edge stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0 up: start_x, start_y, end_x, end_y, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                             s_tlast,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0 up: inside_res, crossings, zero fill
    output logic [RES_TBITS-1:0]             m_tdata
);

    logic [COORD_BITS-1:0] point_x_reg;
    logic [COORD_BITS-1:0] point_y_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;
    logic                  res_push;
    logic                  res_free;
    res_t                  res;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_POINT_X: point_x_reg <= cfg_wdata;
                CFG_POINT_Y: point_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pip_ctrl #(
        .COORD_BITS (COORD_BITS),
        .MAX_EDGES  (MAX_EDGES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .last_edge (s_tlast),
        .point_x   (point_x_reg),
        .point_y   (point_y_reg),
        .res_free  (res_free),
        .res_push  (res_push),
        .res       (res)
    );

    // Result register: the slot is free when empty or being taken.
    assign res_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_push) begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RES_TBITS'(out_reg);

    // A result is only pushed into a free output slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> res_free)
        else $error("result pushed into a full output register");

    // The sequencer never takes an edge while it is deciding the previous one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> !s_tready)
        else $error("edge accepted during a result push");

    // After an edge transfer the block is busy for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held high right after an edge transfer");

    // The inside flag is the parity of the reported count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == m_tdata[1]))
        else $error("inside flag disagrees with crossing count parity");

endmodule
